/* rtl/core/tiq_pkg.sv */
// shared types and constants of the timed input queue
package tiq_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int FRAME_W   = 32;
  localparam int CTRL_W    = 64;
  localparam int OFFSET_W  = 16;
  localparam int DELAY_W   = 8;
  localparam int PEND_W    = 6;
  localparam int CFG_IDX_W = 2;

  // request codes
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_JUMPSQUAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_HOP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEDGEDASH = 2'd2;

  typedef struct packed {
    logic                req_type;
    logic [FRAME_W-1:0]  frame_now;
    logic [CTRL_W-1:0]   controller_state;
    logic [OFFSET_W-1:0] frame_offset;
    logic                add_jumpsquat;
    logic                add_short_hop;
    logic                add_ledgedash;
    logic                reset_stick_count;
  } in_item_t;

  typedef struct packed {
    logic [CTRL_W-1:0]  controller_out;
    logic               fired;
    logic               reset_stick;
    logic               overflow;
    logic [PEND_W-1:0]  pending_count;
    logic [FRAME_W-1:0] earliest_frame;
  } out_item_t;

  // one stored queue entry
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [CTRL_W-1:0]  ctrl;
    logic               rst_flag;
  } entry_t;

endpackage

/* rtl/core/tiq_store.sv */
// entry store: one write port, one registered read port
module tiq_store import tiq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  entry_t          wdata,
  input  logic [AW-1:0]   raddr,
  output entry_t          rdata
);

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/timed_input_queue.sv */
// top level of the timed input queue
//
// Time-ordered queue of controller words held in one entry memory, sorted
// with the latest due frame at address 0 and the earliest at address
// count-1; the earliest due frame is also kept in a register. One item is
// worked on at a time. An add walks the memory from the tail through its
// single read and write port, moving one entry per cycle for each stored
// entry that falls due earlier than the new one, then writes the new entry;
// an add into an empty store writes it directly. A tick that releases an
// entry reads the released entry and, unless it was the last, the next
// earliest entry. A full add is dropped. The output register lets the next
// item be accepted while a result waits to be taken.
module timed_input_queue import tiq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DELAY_W-1:0]   cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_WALK,
    S_ADD_PUT,
    S_TICK_CHECK,
    S_TICK_REFILL,
    S_SEND
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic [CW-1:0]      pos;
  logic [FRAME_W-1:0] head_frame;
  logic [CTRL_W-1:0]  held_ctrl;
  entry_t             new_entry;
  out_item_t          res;
  logic [DELAY_W-1:0] jumpsquat_frames;
  logic [DELAY_W-1:0] short_hop_frames;
  logic [DELAY_W-1:0] ledgedash_frames;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  entry_t             mem_wdata;
  logic [AW-1:0]      mem_raddr;
  entry_t             mem_rdata;

  logic [FRAME_W-1:0] due;
  logic               accept;
  logic               walk_shift;
  logic [CW-1:0]      count_dec;
  logic               out_load;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign count_dec = count - CW'(1);
  assign out_load  = (state == S_SEND) && (!out_valid || !out_stall);

  // due frame of an incoming add, wrapping at 32 bits
  always_comb begin
    due = in_data.frame_now + FRAME_W'(in_data.frame_offset);
    if (in_data.add_jumpsquat) due = due + FRAME_W'(jumpsquat_frames);
    if (in_data.add_short_hop) due = due + FRAME_W'(short_hop_frames);
    if (in_data.add_ledgedash) due = due + FRAME_W'(ledgedash_frames);
  end

  // stored entry moves toward the tail while it falls due before the new one
  assign walk_shift = (mem_rdata.frame < new_entry.frame);

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(pos);
    mem_wdata = new_entry;
    mem_raddr = AW'(count_dec);
    case (state)
      S_IDLE: begin
        mem_waddr = '0;
        mem_wdata = '{frame: due, ctrl: in_data.controller_state,
                      rst_flag: in_data.reset_stick_count};
        mem_we    = accept && (in_data.req_type == REQ_ADD) && (count == '0);
      end
      S_ADD_WALK: begin
        mem_we    = 1'b1;
        mem_raddr = AW'(pos - CW'(2));
        if (walk_shift) mem_wdata = mem_rdata;
      end
      S_ADD_PUT: begin
        mem_we = 1'b1;
      end
      S_TICK_CHECK: begin
        mem_raddr = AW'(count - CW'(2));
      end
      default: begin
      end
    endcase
  end

  tiq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer, queue bookkeeping and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      count            <= '0;
      head_frame       <= '0;
      held_ctrl        <= '0;
      out_valid        <= 1'b0;
      jumpsquat_frames <= '0;
      short_hop_frames <= '0;
      ledgedash_frames <= '0;
    end else begin
      // output register handshake
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_JUMPSQUAT: jumpsquat_frames <= cfg_data;
          CFG_SHORT_HOP: short_hop_frames <= cfg_data;
          CFG_LEDGEDASH: ledgedash_frames <= cfg_data;
          default: begin
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res.controller_out <= held_ctrl;
            res.fired          <= 1'b0;
            res.reset_stick    <= 1'b0;
            res.overflow       <= (in_data.req_type == REQ_ADD) && (count == CW'(DEPTH));
            new_entry <= '{frame: due, ctrl: in_data.controller_state,
                           rst_flag: in_data.reset_stick_count};
            pos       <= count;
            if (in_data.req_type == REQ_ADD) begin
              if (count == CW'(DEPTH)) begin
                // full store: drop the item
                res.pending_count  <= PEND_W'(count);
                res.earliest_frame <= head_frame;
                state              <= S_SEND;
              end else if (count == '0) begin
                count              <= CW'(1);
                head_frame         <= due;
                res.pending_count  <= PEND_W'(CW'(1));
                res.earliest_frame <= due;
                state              <= S_SEND;
              end else begin
                // newest among equal frames goes to the tail
                if (due <= head_frame) head_frame <= due;
                state <= S_ADD_WALK;
              end
            end else begin
              res.pending_count  <= PEND_W'(count);
              res.earliest_frame <= head_frame;
              if ((count != '0) && (in_data.frame_now >= head_frame)) begin
                state <= S_TICK_CHECK;
              end else begin
                state <= S_SEND;
              end
            end
          end
        end

        S_ADD_WALK: begin
          if (walk_shift) begin
            pos <= pos - CW'(1);
            if (pos == CW'(1)) state <= S_ADD_PUT;
          end else begin
            count              <= count + CW'(1);
            res.pending_count  <= PEND_W'(count + CW'(1));
            res.earliest_frame <= head_frame;
            state              <= S_SEND;
          end
        end

        S_ADD_PUT: begin
          count              <= count + CW'(1);
          res.pending_count  <= PEND_W'(count + CW'(1));
          res.earliest_frame <= head_frame;
          state              <= S_SEND;
        end

        S_TICK_CHECK: begin
          // release the earliest entry
          held_ctrl          <= mem_rdata.ctrl;
          count              <= count_dec;
          res.controller_out <= mem_rdata.ctrl;
          res.fired          <= 1'b1;
          res.reset_stick    <= mem_rdata.rst_flag;
          res.pending_count  <= PEND_W'(count_dec);
          if (count_dec == '0) begin
            head_frame         <= '0;
            res.earliest_frame <= '0;
            state              <= S_SEND;
          end else begin
            state <= S_TICK_REFILL;
          end
        end

        S_TICK_REFILL: begin
          head_frame         <= mem_rdata.frame;
          res.earliest_frame <= mem_rdata.frame;
          state              <= S_SEND;
        end

        S_SEND: begin
          if (out_load) begin
            out_data <= res;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* verif/tiq_checker.sv */
// checker for the timed input queue: tracks the sorted store and compares every result
module tiq_checker import tiq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DELAY_W-1:0]   cfg_data,
  output int                   fail_count,
  output int                   results_waiting,
  output int                   results_seen,
  output int                   releases_seen,
  output int                   drops_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted queue contents, earliest due frame at index 0
  entry_t             due_list [DEPTH];
  int                 stored;
  logic [CTRL_W-1:0]  held_word;
  logic [DELAY_W-1:0] jump_delay;
  logic [DELAY_W-1:0] hop_delay;
  logic [DELAY_W-1:0] dash_delay;
  out_item_t          awaited_results [$];

  // apply one item to the predicted queue and return the result it should give
  function automatic out_item_t apply_item(in_item_t it);
    out_item_t          r;
    entry_t             fresh;
    logic [FRAME_W-1:0] due;
    int                 slot;
    int                 i;
    r = '0;
    if (it.req_type == REQ_TICK) begin
      // release only the earliest entry, and only once its frame has come
      if (stored > 0 && it.frame_now >= due_list[0].frame) begin
        held_word = due_list[0].ctrl;
        r.fired = 1'b1;
        r.reset_stick = due_list[0].rst_flag;
        for (i = 1; i < stored; i++) due_list[i-1] = due_list[i];
        stored--;
      end
    end else if (stored >= DEPTH) begin
      r.overflow = 1'b1;
    end else begin
      // due frame wraps at 32 bits
      due = it.frame_now + FRAME_W'(it.frame_offset);
      if (it.add_jumpsquat) due += FRAME_W'(jump_delay);
      if (it.add_short_hop) due += FRAME_W'(hop_delay);
      if (it.add_ledgedash) due += FRAME_W'(dash_delay);
      // newest goes ahead of entries with the same due frame
      slot = 0;
      while (slot < stored && due_list[slot].frame < due) slot++;
      for (i = stored; i > slot; i--) due_list[i] = due_list[i-1];
      fresh.frame = due;
      fresh.ctrl = it.controller_state;
      fresh.rst_flag = it.reset_stick_count;
      due_list[slot] = fresh;
      stored++;
    end
    r.controller_out = held_word;
    r.pending_count = PEND_W'(stored);
    r.earliest_frame = (stored > 0) ? due_list[0].frame : '0;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      stored = 0;
      held_word = '0;
      jump_delay = '0;
      hop_delay = '0;
      dash_delay = '0;
      awaited_results.delete();
      fail_count = 0;
      results_waiting <= 0;
      results_seen = 0;
      releases_seen = 0;
      drops_seen = 0;
    end else begin
      // delay register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_JUMPSQUAT: jump_delay = cfg_data;
          CFG_SHORT_HOP: hop_delay = cfg_data;
          CFG_LEDGEDASH: dash_delay = cfg_data;
          default: ;
        endcase
      end
      // accepted item
      if (in_valid && !in_stall) awaited_results.push_back(apply_item(in_data));
      // accepted result against the oldest expectation
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_data.fired === 1'b1) releases_seen++;
        if (out_data.overflow === 1'b1) drops_seen++;
        if (awaited_results.size() == 0) begin
          $error("result with no item waiting: %h", out_data);
          fail_count++;
        end else begin
          out_item_t want;
          want = awaited_results.pop_front();
          check_field("controller_out", want.controller_out, out_data.controller_out);
          check_field("fired", want.fired, out_data.fired);
          check_field("reset_stick", want.reset_stick, out_data.reset_stick);
          check_field("overflow", want.overflow, out_data.overflow);
          check_field("pending_count", want.pending_count, out_data.pending_count);
          check_field("earliest_frame", want.earliest_frame, out_data.earliest_frame);
        end
      end
      results_waiting <= awaited_results.size();
    end
  end

endmodule

/* verif/tb_timed_input_queue.sv */
// testbench top for the timed input queue: stimulus, handshake idling and verdict
module tb_timed_input_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import tiq_pkg::*;

  localparam int                   WATCH_LIMIT = 2000;
  localparam int                   HOLD_CYCLES = 300;
  localparam int                   NUM_PHASES  = 10;
  localparam int                   PHASE_ITEMS = 128;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DELAY_W-1:0]   cfg_data = '0;

  int fail_count;
  int results_waiting;
  int results_seen;
  int releases_seen;
  int drops_seen;
  int quiet_cycles = 0;
  int settings_used = 0;
  int hold_cycles = 0;
  bit calm = 1'b0;
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;

  always #5 clk = ~clk;

  timed_input_queue uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tiq_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .results_waiting(results_waiting),
    .results_seen(results_seen), .releases_seen(releases_seen), .drops_seen(drops_seen)
  );

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin : result_side
    int n;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!calm && recv_idle && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_item_t add_item(logic [FRAME_W-1:0] frame, logic [OFFSET_W-1:0] ofs,
                                        logic [CTRL_W-1:0] ctrl, logic [2:0] flags,
                                        logic stick);
    in_item_t it;
    it.req_type = REQ_ADD;
    it.frame_now = frame;
    it.controller_state = ctrl;
    it.frame_offset = ofs;
    {it.add_jumpsquat, it.add_short_hop, it.add_ledgedash} = flags;
    it.reset_stick_count = stick;
    return it;
  endfunction

  // ticks carry random filler in the fields they do not use
  function automatic in_item_t tick_item(logic [FRAME_W-1:0] frame);
    in_item_t it;
    it = add_item(frame, OFFSET_W'($urandom), {$urandom, $urandom}, 3'($urandom),
                  1'($urandom));
    it.req_type = REQ_TICK;
    return it;
  endfunction

  // offer one item, optionally after an idle gap, and hold it until taken
  task automatic put_item(input in_item_t it);
    if (!calm && send_idle && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering and wait for every result to come back
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_waiting != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_delays(input logic [DELAY_W-1:0] jump, input logic [DELAY_W-1:0] hop,
                            input logic [DELAY_W-1:0] dash);
    write_reg(CFG_JUMPSQUAT, jump);
    write_reg(CFG_SHORT_HOP, hop);
    write_reg(CFG_LEDGEDASH, dash);
    // unmapped index must leave the delays alone
    write_reg(CFG_SPARE, DELAY_W'($urandom));
    settings_used++;
  endtask

  // random mix of adds and ticks around a moving frame counter
  task automatic run_phase(input int count, input int add_pct, input logic [FRAME_W-1:0] start);
    logic [FRAME_W-1:0]  now;
    logic [FRAME_W-1:0]  frame;
    logic [OFFSET_W-1:0] ofs;
    int                  roll;
    int                  k;
    now = start;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < add_pct) begin
        case ($urandom_range(0, 9))
          0: ofs = OFFSET_W'($urandom);
          1: ofs = '1;
          2: ofs = '0;
          default: ofs = OFFSET_W'($urandom_range(0, 24));
        endcase
        frame = ($urandom_range(0, 19) == 0) ? FRAME_W'($urandom) : now;
        put_item(add_item(frame, ofs, {$urandom, $urandom}, 3'($urandom), 1'($urandom)));
      end else begin
        roll = $urandom_range(0, 19);
        if (roll == 0) frame = '1;
        else if (roll == 1) frame = FRAME_W'($urandom);
        else frame = now;
        put_item(tick_item(frame));
        now += FRAME_W'($urandom_range(0, 6));
      end
    end
  endtask

  initial begin : stimulus
    int p;
    logic [FRAME_W-1:0] start;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed: ordering, equal frames, each delay, wrap, compare at equality
    set_delays(8'd3, 8'd5, 8'd7);
    put_item(tick_item(32'd0));
    put_item(add_item(32'd100, 16'd0, '1, 3'b000, 1'b1));
    put_item(add_item(32'd100, 16'd0, '0, 3'b000, 1'b0));
    put_item(add_item(32'd100, 16'd10, 64'hA5A5_5A5A_C3C3_3C3C, 3'b111, 1'b1));
    put_item(add_item(32'd100, 16'd0, 64'h0123_4567_89AB_CDEF, 3'b100, 1'b0));
    put_item(add_item(32'd100, 16'd0, 64'hFEDC_BA98_7654_3210, 3'b010, 1'b1));
    put_item(add_item(32'd100, 16'd0, 64'h5555_AAAA_5555_AAAA, 3'b001, 1'b0));
    put_item(tick_item(32'd99));
    put_item(tick_item(32'd100));
    put_item(tick_item(32'd100));
    put_item(tick_item(32'd102));
    repeat (4) put_item(tick_item('1));
    put_item(add_item(32'hFFFF_FFF0, '1, 64'hDEAD_BEEF_0000_FFFF, 3'b111, 1'b1));
    put_item(add_item('1, 16'd0, 64'h8000_0000_0000_0001, 3'b000, 1'b0));
    put_item(tick_item(32'd0));
    put_item(tick_item('1));
    put_item(tick_item('1));
    put_item(add_item(32'd0, 16'd0, 64'h0F0F_0F0F_0F0F_0F0F, 3'b000, 1'b1));
    put_item(tick_item(32'd0));
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p == 0) set_delays('0, '0, '0);
      else if (p == 1) set_delays('1, '1, '1);
      else set_delays(DELAY_W'($urandom), DELAY_W'($urandom), DELAY_W'($urandom));
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      calm = (p == NUM_PHASES - 1);
      start = (p == 5) ? 32'hFFFF_FF00 : FRAME_W'($urandom);
      // fill the store past its depth so adds get dropped
      if (p == 1) run_phase(45, 100, start);
      // long result hold while items keep coming
      if (p == 3) begin
        send_idle = 1'b0;
        hold_cycles = HOLD_CYCLES;
      end
      run_phase(PHASE_ITEMS, (p == 1) ? 70 : 45, start);
      drain();
    end

    repeat (40) @(posedge clk);
    $display("covered %0d results, %0d entries released, %0d adds dropped on a full store",
             results_seen, releases_seen, drops_seen);
    $display("used %0d delay settings, with one output hold of %0d cycles",
             settings_used, HOLD_CYCLES);
    if (fail_count == 0 && results_waiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
